### rtl/glcm_pkg.sv
`default_nettype none
package glcm_pkg;

    localparam int LEVELS      = 256;
    localparam int COUNT_WIDTH = 16;
    localparam int MAX_WIDTH   = 4096;
    localparam int HEIGHT_MAX  = 4096;

    localparam int PIX_W   = 8;
    localparam int OUT_W   = 16;
    localparam int CFG_W   = 13;
    localparam int IDX_W   = 2;
    localparam int OP_W    = 2;
    localparam int DIR_W   = 2;

    localparam int CNT_DEPTH = LEVELS * LEVELS;
    localparam int CNT_AW    = $clog2(CNT_DEPTH);
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W     = $clog2(HEIGHT_MAX);
    localparam int WCNT_W    = $clog2(MAX_WIDTH + 1);
    // width for position/size compares, one bit of headroom for the +1
    localparam int CMP_W     = ((WCNT_W > CFG_W) ? WCNT_W : CFG_W) + 1;

    localparam int RST_WIDTH  = 640;
    localparam int RST_HEIGHT = 480;

    typedef enum logic [OP_W-1:0] {
        OP_PIXEL = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2
    } t_op;

    typedef enum logic [IDX_W-1:0] {
        CFG_DIRECTION = 2'd0,
        CFG_WIDTH     = 2'd1,
        CFG_HEIGHT    = 2'd2
    } t_cfg_idx;

    typedef enum logic [DIR_W-1:0] {
        DIR_RIGHT    = 2'd0,
        DIR_DIAG     = 2'd1,
        DIR_DOWN     = 2'd2,
        DIR_UP_RIGHT = 2'd3
    } t_dir;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PX_FETCH,
        ST_PX_UPD,
        ST_RD
    } t_state;

    typedef struct packed {
        logic load_px;    // latch pixel, normalize position, read line buffer
        logic load_rd;    // read count entry for a read op
        logic clr_start;  // restart clear sweep
        logic clr_step;   // zero one entry
        logic pair_step;  // form pair, read its count, update line buffer/holds
        logic bump;       // write back incremented count
        logic out_load;   // present read result
    } t_cmd;

    typedef struct packed {
        logic clr_last;
    } t_stat;

    function automatic logic [OUT_W-1:0] sat_out(input logic [COUNT_WIDTH-1:0] v);
        logic [31:0] vx;
        vx = 32'(v);
        return (vx > 32'hFFFF) ? 16'hFFFF : vx[OUT_W-1:0];
    endfunction

endpackage
`default_nettype wire

### rtl/glcm_ctrl.sv
`default_nettype none
module glcm_ctrl (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      start,
    input  wire logic [glcm_pkg::OP_W-1:0] i_op,
    input  wire glcm_pkg::t_stat           i_stat,
    output glcm_pkg::t_cmd                 o_cmd,
    output logic                           busy
);
    import glcm_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign accept = start && (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (i_stat.clr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (accept) begin
                    case (i_op)
                        OP_PIXEL: n_state = ST_PX_FETCH;
                        OP_READ:  n_state = ST_RD;
                        OP_CLEAR: n_state = ST_CLEAR;
                        default:  n_state = ST_IDLE;
                    endcase
                end
            end
            ST_PX_FETCH: n_state = ST_PX_UPD;
            ST_PX_UPD:   n_state = ST_IDLE;
            ST_RD:       n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        busy  = 1'b1;
        case (r_state)
            ST_CLEAR: o_cmd.clr_step = 1'b1;
            ST_IDLE: begin
                busy = 1'b0;
                o_cmd.load_px   = accept && (i_op == OP_PIXEL);
                o_cmd.load_rd   = accept && (i_op == OP_READ);
                o_cmd.clr_start = accept && (i_op == OP_CLEAR);
            end
            ST_PX_FETCH: o_cmd.pair_step = 1'b1;
            ST_PX_UPD:   o_cmd.bump      = 1'b1;
            ST_RD:       o_cmd.out_load  = 1'b1;
            default:     busy = 1'b1;
        endcase
    end

endmodule
`default_nettype wire

### rtl/glcm_dp.sv
`default_nettype none
module glcm_dp (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire glcm_pkg::t_cmd              i_cmd,
    output glcm_pkg::t_stat                  o_stat,
    input  wire logic                        i_cfg_we,
    input  wire logic [glcm_pkg::IDX_W-1:0]  i_cfg_idx,
    input  wire logic [glcm_pkg::CFG_W-1:0]  i_cfg_data,
    input  wire logic [glcm_pkg::PIX_W-1:0]  i_pixel,
    input  wire logic [glcm_pkg::PIX_W-1:0]  i_first_level,
    input  wire logic [glcm_pkg::PIX_W-1:0]  i_second_level,
    output logic                             o_valid,
    output logic [glcm_pkg::OUT_W-1:0]       o_count
);
    import glcm_pkg::*;

    // config
    logic [DIR_W-1:0]       r_dir;
    logic [CFG_W-1:0]       r_width;
    logic [CFG_W-1:0]       r_height;
    logic [CMP_W-1:0]       w_eff;
    logic [CMP_W-1:0]       h_eff;

    // position and holds
    logic [COL_W-1:0]       r_col;
    logic [ROW_W-1:0]       r_row;
    logic [COL_W-1:0]       c_norm;
    logic [ROW_W-1:0]       r_norm;
    logic [CMP_W-1:0]       col_inc;
    logic [CMP_W-1:0]       row_inc;
    logic [PIX_W-1:0]       r_pixel;
    logic [PIX_W-1:0]       r_prev;
    logic [PIX_W-1:0]       r_diag;
    logic [PIX_W-1:0]       r_lb_q;

    // pair and count store
    logic [PIX_W-1:0]       first;
    logic [PIX_W-1:0]       second;
    logic                   pair_hit;
    logic                   n_pair_ok;
    logic [CNT_AW-1:0]      n_pair_addr;
    logic                   r_pair_ok;
    logic [CNT_AW-1:0]      r_pair_addr;
    logic                   rd_ok;
    logic                   r_rd_ok;
    logic [CNT_AW-1:0]      rd_addr;
    logic [CNT_AW-1:0]      cnt_raddr;
    logic [CNT_AW-1:0]      cnt_waddr;
    logic [COUNT_WIDTH-1:0] cnt_wdata;
    logic                   cnt_we;
    logic [COUNT_WIDTH-1:0] r_cnt_q;
    logic [CNT_AW-1:0]      r_clr_addr;
    logic                   r_out_valid;
    logic [OUT_W-1:0]       r_out_count;

    logic [PIX_W-1:0]       lb_mem  [MAX_WIDTH];
    logic [COUNT_WIDTH-1:0] cnt_mem [CNT_DEPTH];

    function automatic logic lvl_ok(input logic [PIX_W-1:0] lv);
        return 32'(lv) < 32'(LEVELS);
    endfunction

    function automatic logic [CNT_AW-1:0] entry(input logic [PIX_W-1:0] a,
                                                 input logic [PIX_W-1:0] b);
        return CNT_AW'(32'(a) * 32'(LEVELS) + 32'(b));
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir    <= DIR_W'(DIR_RIGHT);
            r_width  <= CFG_W'(RST_WIDTH);
            r_height <= CFG_W'(RST_HEIGHT);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DIRECTION: r_dir    <= i_cfg_data[DIR_W-1:0];
                CFG_WIDTH:     r_width  <= i_cfg_data;
                CFG_HEIGHT:    r_height <= i_cfg_data;
                default:       r_dir    <= r_dir;
            endcase
        end
    end

    // out-of-range sizes clamp to [2, max]
    always_comb begin
        if (CMP_W'(r_width) < CMP_W'(2))              w_eff = CMP_W'(2);
        else if (CMP_W'(r_width) > CMP_W'(MAX_WIDTH)) w_eff = CMP_W'(MAX_WIDTH);
        else                                          w_eff = CMP_W'(r_width);
        if (CMP_W'(r_height) < CMP_W'(2))               h_eff = CMP_W'(2);
        else if (CMP_W'(r_height) > CMP_W'(HEIGHT_MAX)) h_eff = CMP_W'(HEIGHT_MAX);
        else                                            h_eff = CMP_W'(r_height);
    end

    // restart position if the geometry shrank under it
    assign c_norm  = (CMP_W'(r_col) >= w_eff) ? '0 : r_col;
    assign r_norm  = (CMP_W'(r_row) >= h_eff) ? '0 : r_row;
    assign col_inc = CMP_W'(r_col) + CMP_W'(1);
    assign row_inc = CMP_W'(r_row) + CMP_W'(1);

    always_comb begin
        first    = r_prev;
        second   = r_pixel;
        pair_hit = 1'b0;
        case (r_dir)
            DIR_RIGHT: begin
                first    = r_prev;
                second   = r_pixel;
                pair_hit = (r_col != '0);
            end
            DIR_DIAG: begin
                first    = r_diag;
                second   = r_pixel;
                pair_hit = (r_col != '0) && (r_row != '0);
            end
            DIR_DOWN: begin
                first    = r_lb_q;
                second   = r_pixel;
                pair_hit = (r_row != '0);
            end
            DIR_UP_RIGHT: begin
                first    = r_prev;
                second   = r_lb_q;
                pair_hit = (r_col != '0) && (r_row != '0);
            end
            default: pair_hit = 1'b0;
        endcase
    end

    assign n_pair_ok   = pair_hit && lvl_ok(first) && lvl_ok(second);
    assign n_pair_addr = entry(first, second);
    assign rd_ok       = lvl_ok(i_first_level) && lvl_ok(i_second_level);
    assign rd_addr     = entry(i_first_level, i_second_level);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_prev <= '0;
            r_diag <= '0;
        end else if (i_cmd.load_px) begin
            r_col <= c_norm;
            r_row <= r_norm;
        end else if (i_cmd.pair_step) begin
            r_prev <= r_pixel;
            r_diag <= r_lb_q;
            if (col_inc >= w_eff) begin
                r_col <= '0;
                r_row <= (row_inc >= h_eff) ? '0 : row_inc[ROW_W-1:0];
            end else begin
                r_col <= col_inc[COL_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_px) begin
            r_pixel <= i_pixel;
            r_lb_q  <= lb_mem[c_norm];
        end
        if (i_cmd.pair_step) begin
            lb_mem[r_col] <= r_pixel;
            r_pair_ok     <= n_pair_ok;
            r_pair_addr   <= n_pair_addr;
        end
        if (i_cmd.load_rd) r_rd_ok <= rd_ok;
    end

    // count store: one read port, one write port
    assign cnt_raddr = i_cmd.load_rd ? rd_addr : n_pair_addr;
    assign cnt_we    = i_cmd.clr_step ||
                       (i_cmd.bump && r_pair_ok && (r_cnt_q != '1));
    assign cnt_waddr = i_cmd.clr_step ? r_clr_addr : r_pair_addr;
    assign cnt_wdata = i_cmd.clr_step ? '0 : r_cnt_q + COUNT_WIDTH'(1);

    always_ff @(posedge i_clk) begin
        r_cnt_q <= cnt_mem[cnt_raddr];
        if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clr_start) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr_addr <= r_clr_addr + CNT_AW'(1);
        end
    end

    assign o_stat.clr_last = (32'(r_clr_addr) == 32'(CNT_DEPTH - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= i_cmd.out_load;
        end
        if (i_cmd.out_load) r_out_count <= r_rd_ok ? sat_out(r_cnt_q) : '0;
    end

    assign o_valid = r_out_valid;
    assign o_count = r_out_count;

endmodule
`default_nettype wire

### rtl/glcm_pair_counter.sv
// Pixel op: the line buffer is read at the transfer, then busy through a
//   read-modify-write of the count store; the next pixel waits until it ends.
// Read op: o_valid/o_count are registered after the ST_RD state, for one cycle;
//   busy in ST_RD, which holds off the next read. The receiver cannot stall.
// Clear op: zeroes all LEVELS*LEVELS (65536) entries while busy, one per cycle.
// Reset (sync, active low) runs the same clear; config taken anyway.
`default_nettype none
module glcm_pair_counter (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [glcm_pkg::OP_W-1:0]   i_op,
    input  wire logic [glcm_pkg::PIX_W-1:0]  i_pixel,
    input  wire logic [glcm_pkg::PIX_W-1:0]  i_first_level,
    input  wire logic [glcm_pkg::PIX_W-1:0]  i_second_level,
    input  wire logic                        i_cfg_we,
    input  wire logic [glcm_pkg::IDX_W-1:0]  i_cfg_idx,
    input  wire logic [glcm_pkg::CFG_W-1:0]  i_cfg_data,
    output logic                             o_valid,
    output logic [glcm_pkg::OUT_W-1:0]       o_count
);
    import glcm_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // Sequencer: owns the op flow and the clear sweep timing.
    glcm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_op    (i_op),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .busy    (busy)
    );

    // Datapath: config registers, raster position, line buffer, neighbor
    // holds, the count store and the result register.
    glcm_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_pixel        (i_pixel),
        .i_first_level  (i_first_level),
        .i_second_level (i_second_level),
        .o_valid        (o_valid),
        .o_count        (o_count)
    );

    // results never come back to back
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for two cycles");

    // a read transfer yields its result after the ST_RD state
    a_read_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_op == OP_READ) |=> ##1 o_valid)
        else $error("read transfer produced no result");

    // a result only shows while the sequencer is free
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result while busy");

    // clear transfer starts the sweep
    a_clear_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_op == OP_CLEAR) |=> busy)
        else $error("clear did not start sweep");

endmodule
`default_nettype wire

### sim/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import glcm_pkg::*;

    localparam int              CYCLE_LIMIT  = 3_000_000;
    localparam int              RANDOM_ITEMS = 1450;
    localparam int              SOAK_PIXELS  = 150;     // back-to-back pixels on one entry
    localparam int              SETTLE       = 4;       // extra wait once drained
    localparam int              CLEAR_BUDGET = 3;       // each clear costs a full store sweep
    localparam logic [OP_W-1:0] OP_UNUSED    = 2'd3;
    localparam logic [PIX_W-1:0] SOAK_LEVEL  = 8'h5A;

    // ------------------------------------------------------------------
    // Co-occurrence predictor and count checker.
    // Mirrors the pixel walk (position, line above, held left and
    // up-left pixels) and keeps its own copy of the count store.
    // ------------------------------------------------------------------
    class glcm_scoreboard;
        bit [COUNT_WIDTH-1:0] pair_cnt [CNT_DEPTH];
        bit [PIX_W-1:0]       line_above [MAX_WIDTH];
        bit                   above_written [MAX_WIDTH];
        bit [PIX_W-1:0]       left_px;
        bit [PIX_W-1:0]       diag_px;
        int unsigned          col;
        int unsigned          row;
        t_dir                 dir;
        bit [CFG_W-1:0]       width_reg;
        bit [CFG_W-1:0]       height_reg;
        bit [OUT_W-1:0]       count_q [$];
        bit [CNT_AW-1:0]      hot_pairs [$];     // recently bumped entries, read targets
        int                   mismatches;
        int                   reads_seen;

        function new();
            dir        = DIR_RIGHT;
            width_reg  = CFG_W'(RST_WIDTH);
            height_reg = CFG_W'(RST_HEIGHT);
        endfunction

        static function int unsigned clamp_w(bit [CFG_W-1:0] raw);
            if (raw < 2) return 2;
            if (raw > MAX_WIDTH) return MAX_WIDTH;
            return raw;
        endfunction

        static function int unsigned clamp_h(bit [CFG_W-1:0] raw);
            if (raw < 2) return 2;
            if (raw > HEIGHT_MAX) return HEIGHT_MAX;
            return raw;
        endfunction

        function void set_reg(t_cfg_idx idx, bit [CFG_W-1:0] data);
            case (idx)
                CFG_DIRECTION: dir = t_dir'(data[DIR_W-1:0]);
                CFG_WIDTH:     width_reg = data;
                CFG_HEIGHT:    height_reg = data;
                default: ;
            endcase
        endfunction

        // New geometry must never make the block read a line buffer slot
        // that no pixel has written yet.
        function bit geometry_safe(bit [CFG_W-1:0] w_raw, bit [CFG_W-1:0] h_raw);
            int unsigned w;
            int unsigned r;
            w = clamp_w(w_raw);
            r = (row >= clamp_h(h_raw)) ? 0 : row;
            if (r == 0) return 1'b1;
            for (int i = 0; i < w; i++)
                if (!above_written[i]) return 1'b0;
            return 1'b1;
        endfunction

        function void count_pair(bit [PIX_W-1:0] first, bit [PIX_W-1:0] second);
            bit [CNT_AW-1:0] idx;
            idx = {first, second};
            if (pair_cnt[idx] != '1) pair_cnt[idx]++;
            hot_pairs.push_back(idx);
            if (hot_pairs.size() > 16) void'(hot_pairs.pop_front());
        endfunction

        function void accumulate(bit [PIX_W-1:0] px);
            int unsigned    w;
            int unsigned    h;
            int unsigned    c;
            int unsigned    r;
            bit [PIX_W-1:0] above;
            w = clamp_w(width_reg);
            h = clamp_h(height_reg);
            if (col >= w) col = 0;
            if (row >= h) row = 0;
            c = col;
            r = row;
            above = line_above[c];
            case (dir)
                DIR_RIGHT:    if (c >= 1) count_pair(left_px, px);
                DIR_DIAG:     if (c >= 1 && r >= 1) count_pair(diag_px, px);
                DIR_DOWN:     if (r >= 1) count_pair(above, px);
                DIR_UP_RIGHT: if (c >= 1 && r >= 1) count_pair(left_px, above);
                default: ;
            endcase
            diag_px          = above;
            line_above[c]    = px;
            above_written[c] = 1'b1;
            left_px          = px;
            if (c + 1 >= w) begin
                col = 0;
                row = (r + 1 >= h) ? 0 : r + 1;
            end else begin
                col = c + 1;
            end
        endfunction

        function void note_item(logic [OP_W-1:0] op, logic [PIX_W-1:0] px,
                                logic [PIX_W-1:0] a, logic [PIX_W-1:0] b);
            if (op == OP_PIXEL)
                accumulate(px);
            else if (op == OP_READ)
                count_q.push_back(pair_cnt[{a, b}]);
            else if (op == OP_CLEAR)
                foreach (pair_cnt[i]) pair_cnt[i] = '0;
        endfunction

        function void check_count(logic [OUT_W-1:0] got);
            bit [OUT_W-1:0] want;
            reads_seen++;
            if (count_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] count %0d strobed with no read outstanding", $realtime, got);
                return;
            end
            want = count_q.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] count: expected %0d, got %0d", $realtime, want, got);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, DUT, bookkeeping
    // ------------------------------------------------------------------
    logic                i_clk          = 1'b0;
    logic                i_rst_n        = 1'b0;
    logic                start          = 1'b0;
    logic                busy;
    logic [OP_W-1:0]     i_op           = '0;
    logic [PIX_W-1:0]    i_pixel        = '0;
    logic [PIX_W-1:0]    i_first_level  = '0;
    logic [PIX_W-1:0]    i_second_level = '0;
    logic                i_cfg_we       = 1'b0;
    logic [IDX_W-1:0]    i_cfg_idx      = '0;
    logic [CFG_W-1:0]    i_cfg_data     = '0;
    logic                o_valid;
    logic [OUT_W-1:0]    o_count;

    glcm_scoreboard      sb = new();
    int unsigned         cycle_count = 0;
    bit                  steady = 1'b0;      // sender never idles while set
    int                  items_sent = 0;
    int                  random_done = 0;
    int                  clears_left = CLEAR_BUDGET;
    int                  clears_sent = 0;
    logic [PIX_W-1:0]    palette [4];        // per-phase levels so pairs repeat

    always #10 i_clk = ~i_clk;

    glcm_pair_counter DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_op           (i_op),
        .i_pixel        (i_pixel),
        .i_first_level  (i_first_level),
        .i_second_level (i_second_level),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .o_valid        (o_valid),
        .o_count        (o_count)
    );

    // Result monitor plus the run watchdog. The strobe is sampled at the
    // edge that ends its cycle; the receiver cannot push back.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (o_valid === 1'b1) sb.check_count(o_count);
        if (cycle_count == CYCLE_LIMIT) begin
            $display("glcm_pair_counter: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Drivers: inputs move on the falling edge only.
    // ------------------------------------------------------------------

    // One command transfer. Unless steady is set, random idle cycles go
    // in front (junk on the fields), then start is held until an edge sees
    // busy low. Leaves start high; the next task lowers or reuses it.
    task automatic send_item(logic [OP_W-1:0] op, logic [PIX_W-1:0] px,
                             logic [PIX_W-1:0] a, logic [PIX_W-1:0] b);
        @(negedge i_clk);
        while (!steady && $urandom_range(0, 99) < 34) begin
            start          = 1'b0;
            i_op           = OP_W'($urandom);
            i_pixel        = PIX_W'($urandom);
            i_first_level  = PIX_W'($urandom);
            i_second_level = PIX_W'($urandom);
            @(negedge i_clk);
        end
        start          = 1'b1;
        i_op           = op;
        i_pixel        = px;
        i_first_level  = a;
        i_second_level = b;
        do @(posedge i_clk); while (busy);
        sb.note_item(op, px, a, b);
        items_sent++;
        if (op == OP_CLEAR) clears_sent++;
    endtask

    // Stop sending and wait until the block is idle with no read outstanding.
    // Pixel and clear ops give no strobe, so busy is watched as well.
    task automatic drain(int unsigned settle);
        @(negedge i_clk);
        start = 1'b0;
        while (sb.count_q.size() != 0 || busy) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        sb.set_reg(idx, data);
    endtask

    // Mostly small images so rows wrap often; now and then an edge value,
    // including the ones that clamp.
    function automatic logic [CFG_W-1:0] pick_extent();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 12) begin
            case ($urandom_range(0, 4))
                0:       return CFG_W'(0);
                1:       return CFG_W'(1);
                2:       return CFG_W'(4095);
                3:       return CFG_W'(MAX_WIDTH);
                default: return '1;
            endcase
        end
        if (roll < 60) return CFG_W'($urandom_range(2, 6));
        if (roll < 90) return CFG_W'($urandom_range(7, 40));
        return CFG_W'($urandom_range(41, 300));
    endfunction

    // Mid-image geometry change. A width that grows past what the line
    // buffer holds is only allowed once the image is back on its top row;
    // otherwise shrink the height under the current row, or keep the width.
    task automatic reconfigure(t_dir d);
        logic [CFG_W-1:0] w;
        logic [CFG_W-1:0] h;
        w = pick_extent();
        h = pick_extent();
        if (!sb.geometry_safe(w, h)) begin
            if (sb.row >= 2) h = CFG_W'(sb.row);
            if (!sb.geometry_safe(w, h)) w = sb.width_reg;
        end
        // upper data bits are don't-care for the direction register
        write_reg(CFG_DIRECTION, {(CFG_W - DIR_W)'($urandom), d});
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
    endtask

    // Mostly pixel streams; reads lean toward entries just bumped.
    task automatic random_item();
        int unsigned     roll;
        logic [CNT_AW-1:0] idx;
        logic [PIX_W-1:0]  px;
        roll = $urandom_range(0, 999);
        if (roll < 2 && clears_left > 0) begin
            clears_left--;
            send_item(OP_CLEAR, PIX_W'($urandom), PIX_W'($urandom), PIX_W'($urandom));
            random_done++;
        end else if (roll < 32) begin
            // ignored by the block, not counted as stimulus
            send_item(OP_UNUSED, PIX_W'($urandom), PIX_W'($urandom), PIX_W'($urandom));
        end else if (roll < 282) begin
            if (sb.hot_pairs.size() != 0 && $urandom_range(0, 9) < 7)
                idx = sb.hot_pairs[$urandom_range(0, sb.hot_pairs.size() - 1)];
            else
                idx = CNT_AW'($urandom);
            send_item(OP_READ, PIX_W'($urandom), idx[CNT_AW-1:PIX_W], idx[PIX_W-1:0]);
            random_done++;
        end else begin
            px = $urandom_range(0, 1) ? palette[$urandom_range(0, 3)] : PIX_W'($urandom);
            send_item(OP_PIXEL, px, PIX_W'($urandom), PIX_W'($urandom));
            random_done++;
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        int phase;
        int span;

        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        drain(SETTLE);                        // reset sweeps the whole store

        // 2x2 image (out-of-range sizes clamp up), vertical pairs:
        // rows {0,255} / {255,0} give (0,255) and (255,0) once each.
        write_reg(CFG_DIRECTION, CFG_W'(DIR_DOWN));
        write_reg(CFG_WIDTH, CFG_W'(0));
        write_reg(CFG_HEIGHT, CFG_W'(1));
        send_item(OP_PIXEL, 8'h00, 8'h00, 8'h00);
        send_item(OP_PIXEL, 8'hFF, 8'hFF, 8'hFF);
        send_item(OP_PIXEL, 8'hFF, 8'h00, 8'hFF);
        send_item(OP_PIXEL, 8'h00, 8'hFF, 8'h00);
        send_item(OP_READ, 8'h00, 8'h00, 8'hFF);
        send_item(OP_READ, 8'hFF, 8'hFF, 8'h00);
        send_item(OP_READ, 8'h00, 8'h00, 8'h00);
        send_item(OP_READ, 8'hFF, 8'hFF, 8'hFF);
        send_item(OP_UNUSED, 8'hFF, 8'hFF, 8'hFF);
        send_item(OP_CLEAR, 8'h00, 8'h00, 8'h00);
        send_item(OP_READ, 8'h00, 8'h00, 8'hFF);

        // Back-to-back stretch: one level on a 4096-wide image with
        // horizontal pairs bumps a single entry on every pixel after the first.
        drain(SETTLE);
        write_reg(CFG_DIRECTION, CFG_W'(DIR_RIGHT));
        write_reg(CFG_WIDTH, '1);
        write_reg(CFG_HEIGHT, '1);
        steady = 1'b1;
        repeat (SOAK_PIXELS)
            send_item(OP_PIXEL, SOAK_LEVEL, PIX_W'($urandom), PIX_W'($urandom));
        send_item(OP_READ, PIX_W'($urandom), SOAK_LEVEL, SOAK_LEVEL);
        steady = 1'b0;

        // Random phases: every boundary waits for all reads to return, then
        // changes direction and geometry. First four phases walk the directions.
        phase = 0;
        while (random_done < RANDOM_ITEMS) begin
            drain(SETTLE);
            reconfigure((phase < 4) ? t_dir'(phase) : t_dir'($urandom_range(0, 3)));
            foreach (palette[i]) begin
                case ($urandom_range(0, 3))
                    0:       palette[i] = '0;
                    1:       palette[i] = '1;
                    default: palette[i] = PIX_W'($urandom);
                endcase
            end
            steady = ($urandom_range(0, 5) == 0);
            span = $urandom_range(20, 140);
            repeat (span) random_item();
            phase++;
        end
        steady = 1'b0;

        drain(4 * SETTLE);
        $display("%0d transfers, %0d count reads, %0d clears, %0d random phases",
                 items_sent, sb.reads_seen, clears_sent, phase);
        $display("all four pair directions, sizes clamped 2..4096, %0d-pixel back-to-back run",
                 SOAK_PIXELS);
        if (sb.mismatches == 0 && sb.count_q.size() == 0) begin
            $display("glcm_pair_counter: match");
        end else begin
            $display("glcm_pair_counter: mismatch");
        end
        $finish;
    end

endmodule
